>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the AES block.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define AES_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("aes checker: property failed");

// Clocked property that is also checked while reset is asserted.
`define AES_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("aes checker: property failed");

`endif

>>> rtl/aes_pkg.sv
// Shared types, constants and round functions of the AES block.
// Depends on nothing; all RTL files but aes_ram use it by scoped names.
package aes_pkg;

	localparam int BLOCK_BYTES  = 16;
	localparam int BLOCK_W      = BLOCK_BYTES * 8;
	localparam int RK_WORDS_DEF = 60;
	localparam int ROW_W        = 4;
	localparam int CFG_IDX_W    = 3;
	localparam int KEY_REGS     = 4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_0      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_1      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_2      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_3      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 3'd4;

	localparam logic [7:0]  RCON_POLY  = 8'h1b;
	localparam logic [31:0] XT_MASK_HI = 32'hFEFEFEFE;
	localparam logic [31:0] XT_MASK_LO = 32'h01010101;
	localparam logic [31:0] XT_POLY    = 32'h0000001B;

	typedef struct packed {
		logic               en;
		logic [ROW_W-1:0]   row;
		logic [BLOCK_W-1:0] data;
	} rk_wr_t;

	localparam logic [7:0] FWD_SBOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_SUBST [256] = '{
	8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
	8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
	8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
	8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
	8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
	8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
	8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
	8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
	8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
	8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
	8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
	8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
	8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
	8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
	8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
	8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	// Rounds for a key length code; the unused code runs as a 256-bit key.
	function automatic logic [3:0] rounds_for(input logic [1:0] code);
		logic [3:0] nr;
		case (code)
			2'd0:    nr = 4'd10;
			2'd1:    nr = 4'd12;
			default: nr = 4'd14;
		endcase
		return nr;
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] x);
		logic [31:0] v;
		for (int b = 0; b < 4; b++)
			v[8*b +: 8] = FWD_SBOX[x[8*b +: 8]];
		return v;
	endfunction

	// Byte substitution fused with the row shift; row r of column c comes
	// from column c+r (encrypt) or c-r (decrypt).
	function automatic logic [BLOCK_W-1:0] sub_shift(input logic [BLOCK_W-1:0] s,
		input logic dec);
		logic [BLOCK_W-1:0] v;
		logic [1:0]         src;
		logic [7:0]         b;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				src = dec ? 2'(c - r) : 2'(c + r);
				b = s[32*src + 8*r +: 8];
				v[32*c + 8*r +: 8] = dec ? INV_SUBST[b] : FWD_SBOX[b];
			end
		end
		return v;
	endfunction

	function automatic logic [31:0] xtime_word(input logic [31:0] x);
		return ((x << 1) & XT_MASK_HI) ^ (((x >> 7) & XT_MASK_LO) * XT_POLY);
	endfunction

	function automatic logic [31:0] mix_column(input logic [31:0] c);
		logic [31:0] e;
		logic [31:0] t;
		e = c ^ {c[7:0], c[31:8]};
		t = e ^ {e[15:0], e[31:16]};
		return c ^ t ^ xtime_word(e);
	endfunction

	function automatic logic [31:0] inv_mix_column(input logic [31:0] c);
		logic [31:0] e;
		e = c ^ {c[15:0], c[31:16]};
		return mix_column(c ^ xtime_word(xtime_word(e)));
	endfunction

	function automatic logic [BLOCK_W-1:0] mix_all(input logic [BLOCK_W-1:0] s,
		input logic dec);
		logic [BLOCK_W-1:0] v;
		for (int c = 0; c < 4; c++)
			v[32*c +: 32] = dec ? inv_mix_column(s[32*c +: 32]) : mix_column(s[32*c +: 32]);
		return v;
	endfunction

endpackage

>>> rtl/aes_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module aes_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_data <= mem[rd_addr];
	end

endmodule

>>> rtl/aes_key_exp.sv
// Key expansion sequencer: one schedule word per cycle, written by rows.
// Depends on aes_pkg.
module aes_key_exp #(
	parameter int RK_WORDS = aes_pkg::RK_WORDS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [aes_pkg::KEY_REGS*64-1:0]       key,
	input  logic [3:0]                            nr,
	output logic                                  busy,
	output aes_pkg::rk_wr_t                       wr
);

	localparam int ROWS = (RK_WORDS + 3) / 4;

	logic        busy_q;
	logic [5:0]  idx_q;
	logic [2:0]  phase_q;
	logic [7:0]  rc_q;
	logic [31:0] win_q [8];
	logic [95:0] asm_q;

	logic [3:0]  nk;
	logic [31:0] far;
	logic [31:0] t;
	logic [31:0] word;
	logic [31:0] stored;

	always_comb begin
		nk = nr - 4'd6;
		case (nk)
			4'd4:    far = win_q[3];
			4'd6:    far = win_q[5];
			default: far = win_q[7];
		endcase
		t = win_q[0];
		if (phase_q == 3'd0)
			t = aes_pkg::sub_word({t[7:0], t[31:8]}) ^ {24'h0, rc_q};
		else if (nk == 4'd8 && phase_q == 3'd4)
			t = aes_pkg::sub_word(t);
		if (idx_q < {2'b00, nk})
			word = key[32*idx_q[2:0] +: 32];
		else
			word = far ^ t;
		// words past the end of the schedule store read back as zero
		stored = (idx_q < 6'(RK_WORDS)) ? word : '0;
		wr.en = busy_q && idx_q[1:0] == 2'b11 && idx_q[5:2] < 4'(ROWS);
		wr.row = idx_q[5:2];
		wr.data = {stored, asm_q};
	end

	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			idx_q <= '0;
			phase_q <= '0;
			rc_q <= 8'h01;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q <= '0;
			phase_q <= '0;
			rc_q <= 8'h01;
		end else if (busy_q) begin
			idx_q <= idx_q + 6'd1;
			phase_q <= (phase_q == 3'(nk - 4'd1)) ? 3'd0 : phase_q + 3'd1;
			if (idx_q >= {2'b00, nk} && phase_q == 3'd0)
				rc_q <= {rc_q[6:0], 1'b0} ^ (rc_q[7] ? aes_pkg::RCON_POLY : 8'h00);
			if (idx_q == {nr, 2'b11})
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !start) begin
			win_q[0] <= word;
			for (int k = 1; k < 8; k++)
				win_q[k] <= win_q[k-1];
			if (idx_q[1:0] != 2'b11)
				asm_q[32*idx_q[1:0] +: 32] <= stored;
		end
	end

endmodule

>>> rtl/aes_core.sv
// Iterative cipher core: one round per cycle against the round-key memory,
// and a result register that the final round waits on. Depends on aes_pkg.
module aes_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         action,
	input  logic [63:0]                  block_low,
	input  logic [63:0]                  block_high,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [63:0]                  result_low,
	output logic [63:0]                  result_high,
	input  logic                         hold,
	input  logic [3:0]                   nr,
	output logic [aes_pkg::ROW_W-1:0]    rd_row,
	input  logic [aes_pkg::BLOCK_W-1:0]  rk
);

	logic                        busy_q;
	logic                        first_q;
	logic                        dec_q;
	logic [3:0]                  row_q;
	logic [aes_pkg::BLOCK_W-1:0] state_q;
	logic [aes_pkg::BLOCK_W-1:0] res_q;
	logic                        out_valid_q;

	logic                        accept;
	logic                        last;
	logic                        step;
	logic [3:0]                  row_nx;
	logic [3:0]                  start_row;
	logic [aes_pkg::BLOCK_W-1:0] ss;
	logic [aes_pkg::BLOCK_W-1:0] round_out;

	always_comb begin
		in_ready = !busy_q && !hold;
		accept = in_valid && in_ready;
		start_row = action ? nr : 4'd0;
		last = dec_q ? (row_q == 4'd0) : (row_q == nr);
		// the final round waits only for a free result register
		step = busy_q && (first_q || !last || !out_valid_q || out_ready);
		row_nx = dec_q ? row_q - 4'd1 : row_q + 4'd1;
		if (!busy_q)
			rd_row = start_row;
		else if (step)
			rd_row = row_nx;
		else
			rd_row = row_q;
		ss = aes_pkg::sub_shift(state_q, dec_q);
		if (dec_q)
			round_out = last ? ss ^ rk : aes_pkg::mix_all(ss ^ rk, 1'b1);
		else
			round_out = (last ? ss : aes_pkg::mix_all(ss, 1'b0)) ^ rk;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			first_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (accept) begin
				busy_q <= 1'b1;
				first_q <= 1'b1;
			end else if (step) begin
				first_q <= 1'b0;
				if (!first_q && last) begin
					busy_q <= 1'b0;
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dec_q <= action;
			row_q <= start_row;
			state_q <= {block_high, block_low};
		end else if (step) begin
			row_q <= row_nx;
			state_q <= first_q ? state_q ^ rk : round_out;
			if (!first_q && last)
				res_q <= round_out;
		end
	end

	assign out_valid = out_valid_q;
	assign result_low = res_q[63:0];
	assign result_high = res_q[127:64];

endmodule

>>> rtl/aes_block_cipher.sv
// AES block cipher with 128/192/256-bit keys held in configuration.
// Depends on aes_pkg, aes_ram, aes_key_exp and aes_core.
//
// One item is one 128-bit block plus an action bit (0 encrypt, 1 decrypt);
// each item gives one 128-bit result, byte 0 in bits 7:0 of the low word.
// The key lives in five configuration registers (key_0..key_3, key_length
// at indexes 0..4); any write to one of them, and the release of reset,
// rebuilds the round-key schedule into a RAM of 128-bit rows, one schedule
// word per cycle. Items are held off while that runs; writes to indexes
// past the list are taken and ignored. An item occupies the core for one
// key whitening step, then Nr rounds, each step reading one row from the
// key RAM; a new item is taken only once the core is through with the
// last one. The result register lets the next item start while a result
// waits; the last round of that item holds until the register is free.
// Key length code 3 runs as a 256-bit key. With a short schedule
// (ROUND_KEY_WORDS below what the key needs) the missing words read
// as zero.
module aes_block_cipher #(
	parameter int ROUND_KEY_WORDS = aes_pkg::RK_WORDS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            action,
	input  logic [63:0]                     block_low,
	input  logic [63:0]                     block_high,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [63:0]                     result_low,
	output logic [63:0]                     result_high,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [aes_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [63:0]                     cfg_data
);

	localparam int ROWS = (ROUND_KEY_WORDS + 3) / 4;
	localparam int AW   = $clog2(ROWS);

	logic [63:0]                 key_q [aes_pkg::KEY_REGS];
	logic [1:0]                  key_length_q;
	logic                        rd_oob_q;

	logic                        cfg_write;
	logic                        cfg_hit;
	logic [3:0]                  nr;
	logic                        exp_busy;
	aes_pkg::rk_wr_t             rk_wr;
	logic [aes_pkg::ROW_W-1:0]   rd_row;
	logic [aes_pkg::BLOCK_W-1:0] rd_data;
	logic [aes_pkg::BLOCK_W-1:0] rk;

	// Register writes are always taken; a valid index restarts the expansion.
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;
	assign cfg_hit = cfg_write && cfg_index <= aes_pkg::CFG_KEY_LENGTH;
	assign nr = aes_pkg::rounds_for(key_length_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < aes_pkg::KEY_REGS; k++)
				key_q[k] <= '0;
			key_length_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				aes_pkg::CFG_KEY_0:      key_q[0] <= cfg_data;
				aes_pkg::CFG_KEY_1:      key_q[1] <= cfg_data;
				aes_pkg::CFG_KEY_2:      key_q[2] <= cfg_data;
				aes_pkg::CFG_KEY_3:      key_q[3] <= cfg_data;
				aes_pkg::CFG_KEY_LENGTH: key_length_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	aes_key_exp #(
		.RK_WORDS(ROUND_KEY_WORDS)
	) u_key_exp (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cfg_hit),
		.key   ({key_q[3], key_q[2], key_q[1], key_q[0]}),
		.nr    (nr),
		.busy  (exp_busy),
		.wr    (rk_wr)
	);

	aes_ram #(
		.WIDTH(aes_pkg::BLOCK_W),
		.DEPTH(ROWS)
	) u_rk_ram (
		.clk    (clk),
		.wr_en  (rk_wr.en),
		.wr_addr(rk_wr.row[AW-1:0]),
		.wr_data(rk_wr.data),
		.rd_addr(rd_row[AW-1:0]),
		.rd_data(rd_data)
	);

	// Rows past the end of the stored schedule read as zero.
	always_ff @(posedge clk) begin
		rd_oob_q <= rd_row >= aes_pkg::ROW_W'(ROWS);
	end

	assign rk = rd_oob_q ? '0 : rd_data;

	aes_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.block_low  (block_low),
		.block_high (block_high),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result_low (result_low),
		.result_high(result_high),
		.hold       (exp_busy),
		.nr         (nr),
		.rd_row     (rd_row),
		.rk         (rk)
	);

endmodule

>>> rtl/aes_checker.sv
// Port-level checker for aes_block_cipher and its bind statement.
// Depends on aes_pkg and assert_macros.svh.
`include "assert_macros.svh"

module aes_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [63:0]                   result_low,
	input logic [63:0]                   result_high,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [aes_pkg::CFG_IDX_W-1:0] cfg_index
);

	logic rekey;

	assign rekey = cfg_valid && cfg_ready && cfg_index <= aes_pkg::CFG_KEY_LENGTH;

	`AES_ASSERT(a_busy_after_item, clk, arst_n, in_valid && in_ready |=> !in_ready)
	`AES_ASSERT(a_rekey_blocks, clk, arst_n, rekey |=> !in_ready)
	`AES_ASSERT(a_result_held, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(result_low) && $stable(result_high))
	`AES_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |=> !out_valid && !in_ready)

endmodule

bind aes_block_cipher aes_checker u_aes_checker (.*);
